// File: rtl/npsch_pkg.sv
// shared constants and types for the non-preemptive priority scheduler
package npsch_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int VAL_W   = 16;
  localparam int JOB_ID_W = 5;
  localparam int TIME_W  = 21;
  localparam int SUM_W   = 25;
  localparam int ENTRY_W = 3 * VAL_W;

  typedef struct packed {
    logic [VAL_W-1:0] arrival_time;
    logic [VAL_W-1:0] burst_time;
    logic [VAL_W-1:0] priority_req;
    logic             last_job;
  } job_t;

  typedef struct packed {
    logic [JOB_ID_W-1:0] job_id;
    logic [TIME_W-1:0]   completion_time;
    logic [TIME_W-1:0]   turnaround_time;
    logic [TIME_W-1:0]   waiting_time;
    logic [SUM_W-1:0]    sum_turnaround;
    logic [SUM_W-1:0]    sum_waiting;
    logic                last_result;
  } result_t;

  // one row of the job table memory
  typedef struct packed {
    logic [VAL_W-1:0] arrival;
    logic [VAL_W-1:0] burst;
    logic [VAL_W-1:0] prio;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_TALLY,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic eval;
  } scan_ctl_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] pick;
    logic [VAL_W-1:0] pick_arrival;
    logic [VAL_W-1:0] pick_burst;
    logic [VAL_W-1:0] earliest;
  } scan_res_t;

endpackage

// File: rtl/npsch_ram.sv
// generic single-write, single-read ram with registered read data
module npsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/npsch_scan.sv
// running selection over the job table: best ready job and earliest pending arrival
module npsch_scan
  import npsch_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  scan_ctl_t         ctl,
  input  entry_t            entry,
  input  logic [IDX_W-1:0]  idx,
  input  logic              entry_done,
  input  logic [TIME_W-1:0] cur_time,
  output scan_res_t         res
);

  logic             found;
  logic             pending;
  logic [IDX_W-1:0] pick;
  logic [VAL_W-1:0] best_prio;
  logic [VAL_W-1:0] best_arrival;
  logic [VAL_W-1:0] best_burst;
  logic [VAL_W-1:0] earliest;
  logic             ready;
  logic             better;

  assign ready  = TIME_W'(entry.arrival) <= cur_time;
  assign better = ready && (!found || (entry.prio < best_prio));

  always_ff @(posedge clk) begin
    if (rst) begin
      found   <= 1'b0;
      pending <= 1'b0;
    end else if (ctl.clear) begin
      found   <= 1'b0;
      pending <= 1'b0;
    end else if (ctl.eval && !entry_done) begin
      if (!pending || (entry.arrival < earliest)) begin
        earliest <= entry.arrival;
      end
      pending <= 1'b1;
      // strict compare keeps the lowest index on a tie
      if (better) begin
        found        <= 1'b1;
        pick         <= idx;
        best_prio    <= entry.prio;
        best_arrival <= entry.arrival;
        best_burst   <= entry.burst;
      end
    end
  end

  assign res.found        = found;
  assign res.pick         = pick;
  assign res.pick_arrival = best_arrival;
  assign res.pick_burst   = best_burst;
  assign res.earliest     = earliest;

endmodule

// File: rtl/nonpreemptive_priority_scheduler_unit.sv
// Non-preemptive priority scheduler. Jobs are loaded one transaction per cycle
// while busy is low; a job with last_job set starts scheduling of the whole set
// and busy stays high until every result is out. Each dispatch reads the job
// table memory once per loaded job, and an idle gap in arrivals costs one
// more scan. Results appear one per dispatch on result with result_valid
// high for a single cycle; the receiver cannot stall them and must take
// each one as it comes.
module nonpreemptive_priority_scheduler_unit
  import npsch_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  job_t    job,
  output result_t result,
  output logic    result_valid
);

  state_t state, state_next;

  logic [CNT_W-1:0]     job_count;
  logic [CNT_W-1:0]     finished_count;
  logic [CNT_W-1:0]     scan_cnt;
  logic [TIME_W-1:0]    cur_time;
  logic [SUM_W-1:0]     tat_total;
  logic [SUM_W-1:0]     wt_total;
  logic [MAX_PROCS-1:0] done_flags;
  logic [IDX_W-1:0]     eval_idx;
  logic                 eval_valid;
  logic [TIME_W-1:0]    ct;
  logic [TIME_W-1:0]    tat;
  logic [TIME_W-1:0]    wt;

  logic      accept;
  logic      has_room;
  logic      scan_last;
  logic      set_last;
  logic      ram_we;
  logic      ram_re;
  entry_t    wr_entry;
  entry_t    rd_entry;
  scan_ctl_t scan_ctl;
  scan_res_t scan_res;
  logic [SUM_W-1:0] tat_total_next;

  assign accept    = start && !busy;
  assign has_room  = job_count < CNT_W'(MAX_PROCS);
  assign scan_last = scan_cnt == job_count;
  assign set_last  = finished_count == job_count;

  assign wr_entry.arrival = job.arrival_time;
  assign wr_entry.burst   = job.burst_time;
  assign wr_entry.prio    = job.priority_req;

  npsch_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PROCS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (job_count[IDX_W-1:0]),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (scan_cnt[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  npsch_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctl        (scan_ctl),
    .entry      (rd_entry),
    .idx        (eval_idx),
    .entry_done (done_flags[eval_idx]),
    .cur_time   (cur_time),
    .res        (scan_res)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept && job.last_job) state_next = ST_SCAN;
      ST_SCAN:   if (scan_last) state_next = ST_DECIDE;
      ST_DECIDE: state_next = scan_res.found ? ST_TALLY : ST_SCAN;
      ST_TALLY:  state_next = ST_EMIT;
      ST_EMIT:   state_next = set_last ? ST_IDLE : ST_SCAN;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy           = 1'b1;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    scan_ctl.clear = 1'b0;
    scan_ctl.eval  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy           = 1'b0;
        ram_we         = accept && has_room;
        scan_ctl.clear = 1'b1;
      end
      ST_SCAN: begin
        ram_re        = !scan_last;
        scan_ctl.eval = eval_valid;
      end
      ST_DECIDE: begin
        scan_ctl.clear = !scan_res.found;
      end
      ST_TALLY: begin
      end
      ST_EMIT: begin
        scan_ctl.clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign tat_total_next = tat_total + SUM_W'(tat);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      job_count      <= '0;
      finished_count <= '0;
      scan_cnt       <= '0;
      cur_time       <= '0;
      tat_total      <= '0;
      wt_total       <= '0;
      done_flags     <= '0;
      eval_valid     <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      eval_valid   <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          scan_cnt <= '0;
          if (accept && has_room) begin
            job_count <= job_count + 1'b1;
          end
        end
        ST_SCAN: begin
          // read issued now is evaluated next cycle
          eval_valid <= !scan_last;
          eval_idx   <= scan_cnt[IDX_W-1:0];
          scan_cnt   <= scan_cnt + 1'b1;
        end
        ST_DECIDE: begin
          scan_cnt <= '0;
          if (scan_res.found) begin
            ct                       <= cur_time + TIME_W'(scan_res.pick_burst);
            wt                       <= cur_time - TIME_W'(scan_res.pick_arrival);
            done_flags[scan_res.pick] <= 1'b1;
            finished_count           <= finished_count + 1'b1;
          end else begin
            // nothing ready: jump to the earliest pending arrival
            cur_time <= TIME_W'(scan_res.earliest);
          end
        end
        ST_TALLY: begin
          tat      <= ct - TIME_W'(scan_res.pick_arrival);
          wt_total <= wt_total + SUM_W'(wt);
          cur_time <= ct;
        end
        ST_EMIT: begin
          result_valid           <= 1'b1;
          result.job_id          <= JOB_ID_W'(scan_res.pick) + 1'b1;
          result.completion_time <= ct;
          result.turnaround_time <= tat;
          result.waiting_time    <= wt;
          result.sum_turnaround  <= tat_total_next;
          result.sum_waiting     <= wt_total;
          result.last_result     <= set_last;
          if (set_last) begin
            job_count      <= '0;
            finished_count <= '0;
            cur_time       <= '0;
            tat_total      <= '0;
            wt_total       <= '0;
            done_flags     <= '0;
          end else begin
            tat_total <= tat_total_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // results are single-cycle strobes, never back to back
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for two cycles");

  // an idle block holds no partly scheduled set
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (finished_count == '0 && done_flags == '0))
    else $error("idle with dispatched jobs pending");

  // never more dispatches than loaded jobs
  a_finish_bound: assert property (@(posedge clk) disable iff (rst)
    finished_count <= job_count)
    else $error("finished count beyond job count");

  // the final result of a set leaves the block ready for a new set
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last_result) |-> (state == ST_IDLE && job_count == '0))
    else $error("set not cleared after its last result");

  // a dispatch only happens with a ready job selected
  a_dispatch_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TALLY) |-> $past(scan_res.found))
    else $error("dispatch without a selected job");

endmodule
